[design/vlsp_pkg.sv]
// Shared types and constants for the variable-length symbol packer.
`default_nettype none

package vlsp_pkg;

    localparam int COUNT_WIDTH = 40;
    localparam int SYMBOL_W    = 8;
    localparam int WORD_BITS   = 64;
    localparam int FILL_W      = 7;
    localparam int OFFSET_W    = 6;
    localparam int TOTAL_W     = 40;
    localparam int CODE_BITS   = 32;
    localparam int LEN_W       = 6;
    localparam int GROUP_W     = 4;
    localparam int SYMBOL_LIMIT = 48;

    // floor(s / 3) == (s * 43) >> 7 for s below SYMBOL_LIMIT
    localparam int DIV3_MUL    = 43;
    localparam int DIV3_SHIFT  = 7;
    localparam int DIV3_PROD_W = 14;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic [FILL_W-1:0]    word_fill;
        logic                 final_word;
        logic [TOTAL_W-1:0]   bit_total;
        logic                 bad_symbol;
    } result_t;

    // Up to two results produced by one request, oldest in first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

[design/vlsp_sym_if.sv]
// Symbol request channel: valid/ready handshake with symbol payload.
`default_nettype none

interface vlsp_sym_if;
    logic                          valid;
    logic                          ready;
    logic [vlsp_pkg::SYMBOL_W-1:0] symbol;
    logic                          end_of_block;

    modport source (output valid, output symbol, output end_of_block, input ready);
    modport sink   (input valid, input symbol, input end_of_block, output ready);
endinterface

`default_nettype wire

[design/vlsp_word_if.sv]
// Packed word channel: valid/ready handshake with result payload.
`default_nettype none

interface vlsp_word_if;
    logic                           valid;
    logic                           ready;
    logic [vlsp_pkg::WORD_BITS-1:0] packed_word;
    logic [vlsp_pkg::FILL_W-1:0]    word_fill;
    logic                           final_word;
    logic [vlsp_pkg::TOTAL_W-1:0]   bit_total;
    logic                           bad_symbol;

    modport source (output valid, output packed_word, output word_fill, output final_word,
                    output bit_total, output bad_symbol, input ready);
    modport sink   (input valid, input packed_word, input word_fill, input final_word,
                    input bit_total, input bad_symbol, output ready);
endinterface

`default_nettype wire

[design/variable_length_symbol_packer_top.sv]
// Top level of the variable-length symbol packer.
//
// symbols: one symbol (0..47) per request, end_of_block marks the last of a block.
// words:   packed 64-bit words, LSB first, with fill, final flag, bit total and
//          an error flag for symbols of 48 or more.
// A request is taken into an input register, then coded and packed
// combinationally into a four-entry result queue; one request yields zero,
// one or two results. A symbol request reaches its first word through the
// input register and the result queue. Throughput: one symbol per cycle while
// the queue has room for two results; the word channel drains one result per
// cycle while ready, so a block end that also fills a word adds a result.
// When words stalls, the input register holds its symbol and symbols.ready
// drops once the queue cannot take two more results; nothing is lost.
// Reset clears the partial word, the bit offset, the bit counter and the
// queue; no results are pending afterwards.
`default_nettype none

module variable_length_symbol_packer_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vlsp_sym_if.sink    symbols,
    vlsp_word_if.source words
);

    logic                          in_valid_reg;
    logic [vlsp_pkg::SYMBOL_W-1:0] sym_reg;
    logic                          eob_reg;
    logic                          space;
    logic                          advance;
    logic                          load;
    vlsp_pkg::push_t               push;

    assign advance       = in_valid_reg && space;
    assign symbols.ready = !in_valid_reg || advance;
    assign load          = symbols.valid && symbols.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg <= symbols.symbol;
            eob_reg <= symbols.end_of_block;
        end
    end

    vlsp_pack u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .symbol       (sym_reg),
        .end_of_block (eob_reg),
        .push         (push)
    );

    vlsp_rqueue u_rqueue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .words (words)
    );

endmodule

`default_nettype wire

[design/vlsp_pack.sv]
// Code former and word packer: holds the partial word, offset and bit count.
`default_nettype none

module vlsp_pack (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [vlsp_pkg::SYMBOL_W-1:0] symbol,
    input  wire logic                          end_of_block,
    output vlsp_pkg::push_t                    push
);

    logic [vlsp_pkg::WORD_BITS-1:0]   buf_reg, buf_next;
    logic [vlsp_pkg::OFFSET_W-1:0]    fill_reg, fill_next;
    logic [vlsp_pkg::COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic                                bad;
    logic [vlsp_pkg::DIV3_PROD_W-1:0]    div_prod;
    logic [vlsp_pkg::GROUP_W-1:0]        groups;
    logic [1:0]                          rem;
    logic [vlsp_pkg::GROUP_W:0]          two_g;
    logic [vlsp_pkg::CODE_BITS-1:0]      ones;
    logic [vlsp_pkg::CODE_BITS-1:0]      code;
    logic [vlsp_pkg::LEN_W-1:0]          len;
    logic [vlsp_pkg::WORD_BITS+vlsp_pkg::CODE_BITS-1:0] wide;
    logic [vlsp_pkg::WORD_BITS-1:0]      merged;
    logic [vlsp_pkg::WORD_BITS-1:0]      spill;
    logic [vlsp_pkg::FILL_W-1:0]         end_sum;
    logic                                full;
    logic [vlsp_pkg::OFFSET_W-1:0]       new_fill;
    logic [vlsp_pkg::COUNT_WIDTH:0]      cnt_sum;
    logic [vlsp_pkg::COUNT_WIDTH-1:0]    cnt_new;
    logic [vlsp_pkg::TOTAL_W-1:0]        total;
    logic [vlsp_pkg::WORD_BITS-1:0]      buf_after;

    always_comb
    begin
        bad      = (symbol >= vlsp_pkg::SYMBOL_W'(vlsp_pkg::SYMBOL_LIMIT));
        div_prod = vlsp_pkg::DIV3_PROD_W'(symbol) * vlsp_pkg::DIV3_PROD_W'(vlsp_pkg::DIV3_MUL);
        groups   = vlsp_pkg::GROUP_W'(div_prod >> vlsp_pkg::DIV3_SHIFT);
        rem      = 2'(symbol - (vlsp_pkg::SYMBOL_W'({groups, 1'b0}) +
                                vlsp_pkg::SYMBOL_W'(groups)));
        two_g    = {groups, 1'b0};
        ones     = vlsp_pkg::CODE_BITS'((33'(1) << two_g) - 33'(1));
        code     = ones | (vlsp_pkg::CODE_BITS'(rem) << two_g);
        len      = vlsp_pkg::LEN_W'(two_g) + vlsp_pkg::LEN_W'(2);

        wide     = (vlsp_pkg::WORD_BITS + vlsp_pkg::CODE_BITS)'(code) << fill_reg;
        merged   = buf_reg | wide[vlsp_pkg::WORD_BITS-1:0];
        spill    = vlsp_pkg::WORD_BITS'(wide[vlsp_pkg::WORD_BITS+vlsp_pkg::CODE_BITS-1:
                                             vlsp_pkg::WORD_BITS]);
        end_sum  = vlsp_pkg::FILL_W'(fill_reg) + vlsp_pkg::FILL_W'(len);
        full     = end_sum[vlsp_pkg::FILL_W-1];
        new_fill = end_sum[vlsp_pkg::OFFSET_W-1:0];
        buf_after = full ? spill : merged;

        // saturating count: all ones is the limit
        cnt_sum  = (vlsp_pkg::COUNT_WIDTH+1)'(cnt_reg) + (vlsp_pkg::COUNT_WIDTH+1)'(len);
        cnt_new  = cnt_sum[vlsp_pkg::COUNT_WIDTH] ? '1 : cnt_sum[vlsp_pkg::COUNT_WIDTH-1:0];
        total    = vlsp_pkg::TOTAL_W'(cnt_new);
    end

    always_comb
    begin
        push.count  = 2'd0;
        push.first  = '0;
        push.second = '0;
        if (bad)
        begin
            push.count            = 2'd1;
            push.first.bad_symbol = 1'b1;
        end
        else if (full)
        begin
            push.first.packed_word = merged;
            push.first.word_fill   = vlsp_pkg::FILL_W'(vlsp_pkg::WORD_BITS);
            push.first.final_word  = end_of_block && (new_fill == '0);
            push.first.bit_total   = total;
            if (end_of_block && (new_fill != '0))
            begin
                push.count              = 2'd2;
                push.second.packed_word = buf_after;
                push.second.word_fill   = vlsp_pkg::FILL_W'(new_fill);
                push.second.final_word  = 1'b1;
                push.second.bit_total   = total;
            end
            else
            begin
                push.count = 2'd1;
            end
        end
        else if (end_of_block && (new_fill != '0))
        begin
            push.count             = 2'd1;
            push.first.packed_word = merged;
            push.first.word_fill   = vlsp_pkg::FILL_W'(new_fill);
            push.first.final_word  = 1'b1;
            push.first.bit_total   = total;
        end
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        if (fire)
        begin
            if (bad || end_of_block)
            begin
                buf_next  = '0;
                fill_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                buf_next  = buf_after;
                fill_next = new_fill;
                cnt_next  = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[design/vlsp_rqueue.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle while words is ready.
`default_nettype none

module vlsp_rqueue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire vlsp_pkg::push_t push,
    output logic                 space,
    vlsp_word_if.source          words
);

    vlsp_pkg::result_t                mem_reg [vlsp_pkg::QUEUE_DEPTH];
    logic [vlsp_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [vlsp_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [vlsp_pkg::QCOUNT_W-1:0]    cnt_reg, cnt_next;
    logic                             pop;
    vlsp_pkg::result_t                head;

    assign space = (cnt_reg <= vlsp_pkg::QCOUNT_W'(vlsp_pkg::QUEUE_DEPTH - 2));
    assign pop   = (cnt_reg != '0) && words.ready;
    assign head  = mem_reg[rd_reg];

    assign words.valid       = (cnt_reg != '0);
    assign words.packed_word = head.packed_word;
    assign words.word_fill   = head.word_fill;
    assign words.final_word  = head.final_word;
    assign words.bit_total   = head.bit_total;
    assign words.bad_symbol  = head.bad_symbol;

    always_comb
    begin
        wr_next  = wr_reg + vlsp_pkg::QPTR_W'(push.count);
        rd_next  = rd_reg + vlsp_pkg::QPTR_W'(pop);
        cnt_next = cnt_reg + vlsp_pkg::QCOUNT_W'(push.count) - vlsp_pkg::QCOUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_reg + vlsp_pkg::QPTR_W'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire
